@@ rtl/depq_pkg.sv @@
package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 7;

  // command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [1:0] CMD_DEL_MIN = 2'd2;

  // operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_INSERT     = 2'd1,
    OP_SHIFT_DOWN = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [VALUE_W-1:0]  value;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  max_value;
    logic signed [VALUE_W-1:0]  min_value;
    logic [ENTRY_W-1:0]         entry_count;
    logic                       overflow;
  } out_rsp_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                       occ;
    logic                       gt;
    logic signed [VALUE_W-1:0]  data;
  } cell_link_t;

endpackage

@@ rtl/depq_cell.sv @@
module depq_cell
  import depq_pkg::*;
(
  input  logic                       clk,
  input  op_t                        op,
  input  logic signed [VALUE_W-1:0]  ins_value,
  input  logic                       occ_self,
  input  cell_link_t                 link_below,
  input  cell_link_t                 link_above,
  output cell_link_t                 link_self
);

  logic signed [VALUE_W-1:0] data_r;
  logic signed [VALUE_W-1:0] data_nxt;
  logic                      gt_self;

  // new value goes after entries equal to it
  assign gt_self = occ_self && (ins_value < data_r);

  always_comb begin
    data_nxt = data_r;
    case (op)
      OP_INSERT: begin
        if (gt_self) begin
          data_nxt = link_below.gt ? link_below.data : ins_value;
        end else if (!occ_self && link_below.occ) begin
          // first free cell takes the old top when it moves up, else the new value
          data_nxt = link_below.gt ? link_below.data : ins_value;
        end
      end
      OP_SHIFT_DOWN: begin
        if (link_above.occ) begin
          data_nxt = link_above.data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link_self.occ  = occ_self;
  assign link_self.gt   = gt_self;
  assign link_self.data = data_r;

endmodule

@@ rtl/double_ended_priority_queue_unit.sv @@
// Sorted queue of up to CAPACITY signed values held in a row of cells, smallest
// in cell 0. Every request (insert, delete maximum, delete minimum) is applied to
// all cells at once at the clock edge that accepts it, so one request is taken per
// cycle while no pending result is held back by out_stall; its result is read from
// the updated row into the output register, and a new request is accepted in the
// same cycle that the previous result is loaded. An insert into a full queue
// leaves the contents untouched and returns overflow set; deletes on an empty
// queue and the unused command code change nothing.
module double_ended_priority_queue_unit
  import depq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_req_t   in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output out_rsp_t  out_rsp
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             pend_r;
  logic             pend_ovf_r;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r;

  logic             acc;
  logic             can_load;
  logic             is_full;
  logic             is_empty;
  logic             ovf_nxt;
  op_t              op;

  logic [CAPACITY-1:0] occ;
  cell_link_t          link [CAPACITY];
  cell_link_t          below_link [CAPACITY];
  cell_link_t          above_link [CAPACITY];

  logic signed [VALUE_W-1:0] max_sel;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = pend_r && !can_load;
  assign acc      = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    op        = OP_HOLD;
    count_nxt = count_r;
    ovf_nxt   = 1'b0;
    if (acc) begin
      case (in_req.cmd)
        CMD_INSERT: begin
          if (is_full) begin
            ovf_nxt = 1'b1;
          end else begin
            op        = OP_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        CMD_DEL_MAX: begin
          if (!is_empty) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        CMD_DEL_MIN: begin
          if (!is_empty) begin
            op        = OP_SHIFT_DOWN;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          op = OP_HOLD;
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_bottom
        assign below_link[gi] = '{occ: 1'b1, gt: 1'b0, data: '0};
      end else begin : g_mid_lo
        assign below_link[gi] = link[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_top
        assign above_link[gi] = '{occ: 1'b0, gt: 1'b0, data: '0};
      end else begin : g_mid_hi
        assign above_link[gi] = link[gi+1];
      end

      depq_cell u_cell (
        .clk        (clk),
        .op         (op),
        .ins_value  (in_req.value),
        .occ_self   (occ[gi]),
        .link_below (below_link[gi]),
        .link_above (above_link[gi]),
        .link_self  (link[gi])
      );
    end
  endgenerate

  // top occupied cell is the only one whose upper neighbor is empty
  always_comb begin
    max_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (occ[i] && !above_link[i].occ) begin
        max_sel = max_sel | link[i].data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        pend_r <= 1'b1;
      end else if (can_load) begin
        pend_r <= 1'b0;
      end
      if (can_load) begin
        out_valid_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_ovf_r <= ovf_nxt;
    end
    if (pend_r && can_load) begin
      out_rsp_r.max_value   <= max_sel;
      out_rsp_r.min_value   <= is_empty ? '0 : link[0].data;
      out_rsp_r.entry_count <= ENTRY_W'(count_r);
      out_rsp_r.overflow    <= pend_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_ovf_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ovf_nxt |=> $stable(count_r))
    else $error("dropped insert changed occupancy");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && can_load |=> out_valid_r)
    else $error("pending result not presented");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !is_empty |-> link[0].data <= max_sel)
    else $error("row not in ascending order");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import depq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_ITEMS = 900;
  localparam int NUM_ROWS = 25;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fffffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h80000000;

  typedef struct {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    out_rsp_t                  rsp;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  logic signed [VALUE_W-1:0] sorted_model[$];
  out_rsp_t                  pending_results[$];
  int                        mismatches = 0;
  int                        requests_sent = 0;
  int                        idle_pct = 18;
  int                        hold_len = 0;

  // Rows with a typed result read straight off the queue contents; the rest use
  // the predictor.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_DEL_MAX, 32'h0,        1'b1, '{32'h0, 32'h0, 7'd0, 1'b0}},
    '{CMD_DEL_MIN, 32'hffffffff, 1'b1, '{32'h0, 32'h0, 7'd0, 1'b0}},
    '{CMD_UNUSED,  32'h0,        1'b1, '{32'h0, 32'h0, 7'd0, 1'b0}},
    '{CMD_INSERT,  VAL_MAX,      1'b1, '{VAL_MAX, VAL_MAX, 7'd1, 1'b0}},
    '{CMD_INSERT,  VAL_MIN,      1'b1, '{VAL_MAX, VAL_MIN, 7'd2, 1'b0}},
    '{CMD_INSERT,  32'h0,        1'b1, '{VAL_MAX, VAL_MIN, 7'd3, 1'b0}},
    '{CMD_INSERT,  32'hffffffff, 1'b0, '0},
    '{CMD_INSERT,  32'h1,        1'b0, '0},
    '{CMD_UNUSED,  32'hffffffff, 1'b0, '0},
    '{CMD_INSERT,  VAL_MAX,      1'b0, '0},
    '{CMD_DEL_MAX, 32'h0,        1'b0, '0},
    '{CMD_DEL_MAX, 32'h12345678, 1'b0, '0},
    '{CMD_INSERT,  VAL_MIN,      1'b0, '0},
    '{CMD_DEL_MIN, 32'h0,        1'b0, '0},
    '{CMD_DEL_MIN, 32'h0,        1'b0, '0},
    '{CMD_INSERT,  32'h55555555, 1'b0, '0},
    '{CMD_INSERT,  32'haaaaaaaa, 1'b0, '0},
    '{CMD_DEL_MAX, 32'h0,        1'b0, '0},
    '{CMD_DEL_MIN, 32'h0,        1'b0, '0},
    '{CMD_DEL_MIN, 32'h0,        1'b0, '0},
    '{CMD_DEL_MIN, 32'h0,        1'b0, '0},
    '{CMD_DEL_MAX, 32'h0,        1'b0, '0},
    '{CMD_DEL_MAX, 32'h0,        1'b1, '{32'h0, 32'h0, 7'd0, 1'b0}},
    '{CMD_INSERT,  32'h12345678, 1'b1, '{32'h12345678, 32'h12345678, 7'd1, 1'b0}},
    '{CMD_DEL_MIN, 32'h0,        1'b1, '{32'h0, 32'h0, 7'd0, 1'b0}}
  };

  double_ended_priority_queue_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Apply one request to the sorted contents and return the queue's new extremes, count and overflow flag.
  function automatic out_rsp_t queue_after_request(input logic [1:0] cmd,
                                                   input logic signed [VALUE_W-1:0] value);
    out_rsp_t rsp;
    int pos;
    rsp = '0;
    case (cmd)
      CMD_INSERT: begin
        if (sorted_model.size() >= CAPACITY) begin
          rsp.overflow = 1'b1;
        end else begin
          pos = 0;
          while (pos < sorted_model.size() && sorted_model[pos] <= value) pos++;
          sorted_model.insert(pos, value);
        end
      end
      CMD_DEL_MAX: begin
        if (sorted_model.size() > 0) sorted_model.delete(sorted_model.size() - 1);
      end
      CMD_DEL_MIN: begin
        if (sorted_model.size() > 0) sorted_model.delete(0);
      end
      default: ;
    endcase
    if (sorted_model.size() > 0) begin
      rsp.max_value = sorted_model[sorted_model.size() - 1];
      rsp.min_value = sorted_model[0];
    end
    rsp.entry_count = ENTRY_W'(sorted_model.size());
    return rsp;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 15)) - 8;
      7:          return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      8:          return VAL_MAX - $urandom_range(0, 3);
      default:    return VAL_MIN + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] value,
                              input bit typed, input out_rsp_t typed_rsp);
    out_rsp_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_req <= '{cmd: 2'($urandom), value: $urandom};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{cmd: cmd, value: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = queue_after_request(cmd, value);
    pending_results.insert(pending_results.size(), typed ? typed_rsp : predicted);
    requests_sent++;
  endtask

  task automatic send_mixed(input int count);
    logic [1:0] cmd;
    repeat (count) begin
      case ($urandom_range(0, 99)) inside
        [0:47]:  cmd = CMD_INSERT;
        [48:71]: cmd = CMD_DEL_MAX;
        [72:95]: cmd = CMD_DEL_MIN;
        default: cmd = CMD_UNUSED;
      endcase
      send_request(cmd, pick_value(), 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(out_rsp.entry_count), 0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_rsp.max_value !== want.max_value)
          report_mismatch("max_value", out_rsp.max_value, want.max_value);
        if (out_rsp.min_value !== want.min_value)
          report_mismatch("min_value", out_rsp.min_value, want.min_value);
        if (out_rsp.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_rsp.entry_count), 32'(want.entry_count));
        if (out_rsp.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_rsp.overflow), 32'(want.overflow));
      end
    end
  end

  initial begin
    int phase;
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_request(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].rsp);

    phase = 0;
    while (requests_sent < NUM_ITEMS) begin
      phase++;
      if (phase == 3) begin
        // no idling on either side for a while
        idle_pct = 0;
        send_mixed(120);
        idle_pct = 18;
      end else if (phase == 5) begin
        // hold the results back; the sender keeps offering until the block stalls
        hold_len = 150;
        send_mixed(20);
      end else if (phase == 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        send_mixed(10);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            // fill to capacity and push a few past it
            repeat (CAPACITY - sorted_model.size() + $urandom_range(1, 6))
              send_request(CMD_INSERT, pick_value(), 1'b0, '0);
          end
          1: begin
            // drain past empty
            repeat (sorted_model.size() + $urandom_range(1, 4))
              send_request($urandom_range(0, 1) ? CMD_DEL_MAX : CMD_DEL_MIN,
                           pick_value(), 1'b0, '0);
          end
          default: send_mixed($urandom_range(10, 40));
        endcase
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("requests left without result", pending_results.size(), 0);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/depq_pkg.sv
rtl/depq_cell.sv
rtl/double_ended_priority_queue_unit.sv
tb/sv/testbench.sv
